/* hdl/bbc_pkg.sv */
// Package for the bracket balance checker: operation word, bracket kinds,
// status codes and the character classifier. No dependencies.
package bbc_pkg;

  localparam int unsigned StackDepthDef = 64;
  localparam int unsigned QueueDepth    = 2;

  typedef logic [1:0] kind_t;
  typedef logic [2:0] status_t;

  localparam kind_t KIND_ROUND  = 2'd0;
  localparam kind_t KIND_CURLY  = 2'd1;
  localparam kind_t KIND_SQUARE = 2'd2;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_MISMATCH = 3'd1;
  localparam status_t ST_EMPTY    = 3'd2;
  localparam status_t ST_UNCLOSED = 3'd3;
  localparam status_t ST_OVERFLOW = 3'd4;

  localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
  localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
  localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
  localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;

  typedef enum logic [2:0] {
    OP_NONE = 3'b001,
    OP_PUSH = 3'b010,
    OP_POP  = 3'b100
  } op_e;

  typedef struct packed {
    op_e   op;
    kind_t kind;
    logic  last;
  } op_t;

  function automatic op_t classify(logic [7:0] c, logic last);
    op_t r;
    r.op   = OP_NONE;
    r.kind = KIND_ROUND;
    r.last = last;
    case (c)
      CH_OPEN_ROUND: begin
        r.op = OP_PUSH; r.kind = KIND_ROUND;
      end
      CH_OPEN_CURLY: begin
        r.op = OP_PUSH; r.kind = KIND_CURLY;
      end
      CH_OPEN_SQUARE: begin
        r.op = OP_PUSH; r.kind = KIND_SQUARE;
      end
      CH_CLOSE_ROUND: begin
        r.op = OP_POP; r.kind = KIND_ROUND;
      end
      CH_CLOSE_CURLY: begin
        r.op = OP_POP; r.kind = KIND_CURLY;
      end
      CH_CLOSE_SQUARE: begin
        r.op = OP_POP; r.kind = KIND_SQUARE;
      end
      default: begin
        r.op = OP_NONE;
      end
    endcase
    return r;
  endfunction

endpackage

/* hdl/bbc_in_if.sv */
// Input channel of the bracket balance checker: one character word per handshake.
// Depends on nothing.
interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

/* hdl/bbc_out_if.sv */
// Output channel of the bracket balance checker: one result word per string.
// Depends on nothing.
interface bbc_out_if;
  logic       valid;
  logic       ready;
  logic       balanced;
  logic [2:0] status;

  modport source (output valid, output balanced, output status, input ready);
  modport sink   (input valid, input balanced, input status, output ready);
endinterface

/* hdl/bbc_queue.sv */
// Short queue of operation words between the front and back of the checker.
// Depends on bbc_pkg.
module bbc_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_valid_i,
  output logic         wr_ready_o,
  input  bbc_pkg::op_t wr_data_i,
  output logic         rd_valid_o,
  input  logic         rd_ready_i,
  output bbc_pkg::op_t rd_data_o
);
  import bbc_pkg::*;

  localparam int unsigned PW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned NW = $clog2(QueueDepth + 1);

  op_t            slot_q [QueueDepth];
  logic [PW-1:0]  wptr_q, rptr_q;
  logic [NW-1:0]  fill_q;
  logic           push, pop;

  assign wr_ready_o = fill_q != NW'(QueueDepth);
  assign rd_valid_o = fill_q != '0;
  assign rd_data_o  = slot_q[rptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PW'(QueueDepth - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (pop) begin
        rptr_q <= (rptr_q == PW'(QueueDepth - 1)) ? '0 : rptr_q + PW'(1);
      end
      if (push && !pop) begin
        fill_q <= fill_q + NW'(1);
      end else if (pop && !push) begin
        fill_q <= fill_q - NW'(1);
      end
    end
  end
endmodule

/* hdl/bbc_front.sv */
// Front of the checker: accept character words, classify them into push, pop
// or no-op words. Depends on bbc_pkg and bbc_in_if.
module bbc_front (
  bbc_in_if.sink       in_i,
  output logic         op_valid_o,
  input  logic         op_ready_i,
  output bbc_pkg::op_t op_o
);
  import bbc_pkg::*;

  assign in_i.ready = op_ready_i;
  assign op_valid_o = in_i.valid;
  assign op_o       = classify(in_i.char_code, in_i.last_char);
endmodule

/* hdl/bbc_back.sv */
// Back of the checker: bracket stack with the top held in a register, the
// rest in memory, error latch and result register. Depends on bbc_pkg, bbc_out_if.
module bbc_back #(
  parameter int unsigned STACK_DEPTH = bbc_pkg::StackDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         op_valid_i,
  output logic         op_ready_o,
  input  bbc_pkg::op_t op_i,
  bbc_out_if.source    out_o
);
  import bbc_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  kind_t          mem [STACK_DEPTH];
  logic [CW-1:0]  cnt_q, cnt_d, step_cnt;
  kind_t          top_q, top_d, rd_q, byp_data_q, under;
  logic           byp_q, wr_en, fire;
  status_t        err_q, err_d, step_err, res_status;
  logic [AW-1:0]  waddr, raddr;
  logic           out_valid_q;
  status_t        out_status_q;

  assign op_ready_o = !op_i.last || !out_valid_q || out_o.ready;
  assign fire       = op_valid_i && op_ready_o;
  assign under      = byp_q ? byp_data_q : rd_q;
  assign waddr      = AW'(cnt_q - CW'(1));

  always_comb begin
    step_cnt = cnt_q;
    step_err = err_q;
    top_d    = top_q;
    wr_en    = 1'b0;
    if (fire && (err_q == ST_OK)) begin
      case (op_i.op)
        OP_PUSH: begin
          if (cnt_q == CW'(STACK_DEPTH)) begin
            step_err = ST_OVERFLOW;
          end else begin
            wr_en    = cnt_q != '0;
            top_d    = op_i.kind;
            step_cnt = cnt_q + CW'(1);
          end
        end
        OP_POP: begin
          if (cnt_q == '0) begin
            step_err = ST_EMPTY;
          end else begin
            top_d    = under;
            step_cnt = cnt_q - CW'(1);
            if (top_q != op_i.kind) begin
              step_err = ST_MISMATCH;
            end
          end
        end
        default: begin
        end
      endcase
    end
    res_status = step_err;
    if ((step_err == ST_OK) && (step_cnt != '0)) begin
      res_status = ST_UNCLOSED;
    end
    cnt_d = step_cnt;
    err_d = step_err;
    if (fire && op_i.last) begin
      cnt_d = '0;
      err_d = ST_OK;
    end
  end

  assign raddr = AW'(cnt_d - CW'(2));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= top_q;
    end
    rd_q       <= mem[raddr];
    byp_data_q <= top_q;
    top_q      <= top_d;
    if (fire && op_i.last) begin
      out_status_q <= res_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      err_q       <= ST_OK;
      byp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      err_q <= err_d;
      byp_q <= wr_en;
      if (fire && op_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.status   = out_status_q;
  assign out_o.balanced = out_status_q == ST_OK;
endmodule

/* hdl/bracket_balance_checker_core.sv */
// Top level of the bracket balance checker: front, queue and back joined.
// Depends on bbc_pkg, bbc_in_if, bbc_out_if, bbc_front, bbc_queue, bbc_back.
//
// Takes one character word per cycle while not stalled and gives one result
// word per string, on the word marked last: status 0 balanced, 1 kind
// mismatch, 2 close on an empty stack, 3 open bracket left, 4 stack overflow
// (more than STACK_DEPTH opens pending). The stack's top entry sits in a
// register and the entries below it in a memory with one write and one
// registered read port, so pushes and pops, consecutive pops too, need no
// stall. A result passes through the queue and the back's result register
// after its last character is taken. The front stalls only when a result is
// still waiting in the output register and the next string's last character
// reaches the back, once the two-word queue has filled.
module bracket_balance_checker_core #(
  parameter int unsigned STACK_DEPTH = bbc_pkg::StackDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bbc_in_if.sink    in_i,
  bbc_out_if.source out_o
);
  import bbc_pkg::*;

  logic f_valid, f_ready, b_valid, b_ready;
  op_t  f_op, b_op;

  bbc_front u_front (
    .in_i       (in_i),
    .op_valid_o (f_valid),
    .op_ready_i (f_ready),
    .op_o       (f_op)
  );

  bbc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (f_op),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  (b_op)
  );

  bbc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (b_valid),
    .op_ready_o (b_ready),
    .op_i       (b_op),
    .out_o      (out_o)
  );
endmodule
